>>> hdl/iprt_pkg.sv
// Shared types and constants for the IPv4 fragment reassembly tracker.
`default_nettype none
package iprt_pkg;

    localparam int unsigned HDR_LEN = 20;
    localparam logic [16:0] CNT_MAX = 17'h1FFFF;

    // Lookup key of a reassembly entry
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
    } t_key;

    // Request as seen by every cell, payload length already worked out
    typedef struct packed {
        t_key        key;
        logic [15:0] offs;
        logic [15:0] flen;
        logic [5:0]  olen;
        logic        mf;
    } t_req;

    // Broadcast control from the sequencer to the cells
    typedef struct packed {
        logic cmp;      // compare key, latch hit/free flags
        logic upd;      // read-modify-write of the selected entry
        logic any_hit;  // some cell holds the key
        logic any_free; // some cell is free
    } t_ctl;

    // Result handed along the cell row
    typedef struct packed {
        logic [2:0]  entry;
        logic        complete;
        logic [16:0] payload;
        logic [16:0] full;
    } t_res;

endpackage
`default_nettype wire

>>> hdl/iprt_cell.sv
// One table entry of the reassembly tracker, chained to its neighbors.
`default_nettype none
module iprt_cell #(
    parameter int IW  = 3,
    parameter int IDX = 0
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  iprt_pkg::t_ctl    i_ctl,
    input  iprt_pkg::t_req    i_req,
    input  wire  [IW-1:0]     i_victim,
    input  wire               i_hit_before,
    input  wire               i_free_before,
    output logic              o_hit_after,
    output logic              o_free_after,
    input  iprt_pkg::t_res    i_res,
    output iprt_pkg::t_res    o_res
);

    logic            r_valid;
    iprt_pkg::t_key  r_key;
    logic [16:0]     r_recv;
    logic [16:0]     r_exp;
    logic [5:0]      r_opt;
    logic            r_hit;
    logic            r_free;

    logic            sel;
    logic            claim;
    logic [16:0]     base_recv;
    logic [17:0]     sum;
    logic [16:0]     n_recv;
    logic [16:0]     exp_new;
    logic [5:0]      n_opt;
    logic            done;
    logic [17:0]     full_sum;
    iprt_pkg::t_res  mine;

    assign o_hit_after  = i_hit_before | r_hit;
    assign o_free_after = i_free_before | r_free;

    // lowest hit, else lowest free, else the round-robin victim
    always_comb begin
        if (i_ctl.any_hit) begin
            sel = r_hit & ~i_hit_before;
        end else if (i_ctl.any_free) begin
            sel = r_free & ~i_free_before;
        end else begin
            sel = (i_victim == IW'(IDX));
        end
    end

    assign claim     = ~i_ctl.any_hit;
    assign base_recv = claim ? 17'd0 : r_recv;
    assign sum       = {1'b0, base_recv} + {2'b00, i_req.flen};
    assign n_recv    = sum[17] ? iprt_pkg::CNT_MAX : sum[16:0];

    always_comb begin
        if (!i_req.mf) begin
            exp_new = {1'b0, i_req.offs} + {1'b0, i_req.flen};
        end else if (claim) begin
            exp_new = 17'd0;
        end else begin
            exp_new = r_exp;
        end
    end

    assign n_opt    = (claim || (i_req.offs == 16'd0)) ? i_req.olen : r_opt;
    assign done     = (exp_new != 17'd0) && (exp_new == n_recv);
    assign full_sum = {1'b0, exp_new} + 18'(iprt_pkg::HDR_LEN) + {12'd0, n_opt};

    always_comb begin
        mine.entry    = 3'(IDX);
        mine.complete = done;
        mine.payload  = done ? exp_new : 17'd0;
        if (!done) begin
            mine.full = 17'd0;
        end else if (full_sum[17]) begin
            mine.full = iprt_pkg::CNT_MAX;
        end else begin
            mine.full = full_sum[16:0];
        end
    end

    assign o_res = sel ? mine : i_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_hit  <= r_valid && (r_key == i_req.key);
                r_free <= ~r_valid;
            end
            if (i_ctl.upd && sel) begin
                r_valid <= ~done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && sel) begin
            if (claim) begin
                r_key <= i_req.key;
            end
            r_recv <= n_recv;
            r_exp  <= done ? 17'd0 : exp_new;
            r_opt  <= n_opt;
        end
    end

endmodule
`default_nettype wire

>>> hdl/ip_fragment_reassembly_tracker_unit.sv
// Top level of the IPv4 fragment reassembly tracker: sequencer and row of entry cells.
`default_nettype none
// Takes one IPv4 fragment header per request and returns one result per request.
// The table is a row of ENTRIES cells, one entry each. A request goes from acceptance
// to a ready result through the accept cycle, a compare cycle in which every
// cell checks the key against its own entry, and an update cycle in which the
// hit/free priority ripples down the cell row, the chosen cell does its
// read-modify-write and the result is passed along the row into the output
// register. A new request is taken only once the update cycle is done; a result
// waiting in the output register does not block the next request, but a second
// result holds the update cycle until the first one is taken. An in-use entry
// matching the key wins (lowest index first), otherwise the lowest free entry is
// claimed, otherwise the entry at the round-robin victim pointer is evicted.
// No clearing pass is needed after reset.
module ip_fragment_reassembly_tracker_unit #(
    parameter int ENTRIES = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [15:0] i_frag_id,
    input  wire  [31:0] i_src_addr,
    input  wire  [31:0] i_dst_addr,
    input  wire  [7:0]  i_proto_num,
    input  wire  [15:0] i_frag_offset,
    input  wire  [15:0] i_total_length,
    input  wire  [5:0]  i_options_length,
    input  wire         i_more_frags,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_entry_index,
    output logic        o_new_entry,
    output logic        o_evicted,
    output logic        o_complete,
    output logic [16:0] o_payload_length,
    output logic [16:0] o_full_length
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state          r_state;
    iprt_pkg::t_req  r_req;
    logic [IW-1:0]   r_victim;

    logic            in_take;
    logic            upd_en;
    iprt_pkg::t_ctl  ctl;

    // priority and result chains along the cell row
    logic            hit_chain  [ENTRIES+1];
    logic            free_chain [ENTRIES+1];
    iprt_pkg::t_res  res_chain  [ENTRIES+1];

    assign o_stall = (r_state != S_IDLE);
    assign in_take = i_valid && !o_stall;
    // update only when the output register can take the result
    assign upd_en  = (r_state == S_UPD) && (!o_valid || !i_stall);

    assign ctl.cmp      = (r_state == S_CMP);
    assign ctl.upd      = upd_en;
    assign ctl.any_hit  = hit_chain[ENTRIES];
    assign ctl.any_free = free_chain[ENTRIES];

    assign hit_chain[0]  = 1'b0;
    assign free_chain[0] = 1'b0;
    assign res_chain[0]  = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        iprt_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_req         (r_req),
            .i_victim      (r_victim),
            .i_hit_before  (hit_chain[g]),
            .i_free_before (free_chain[g]),
            .o_hit_after   (hit_chain[g+1]),
            .o_free_after  (free_chain[g+1]),
            .i_res         (res_chain[g]),
            .o_res         (res_chain[g+1])
        );
    end

    // request register; payload length wraps modulo 65536
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req.key.id    <= i_frag_id;
            r_req.key.src   <= i_src_addr;
            r_req.key.dst   <= i_dst_addr;
            r_req.key.proto <= i_proto_num;
            r_req.offs      <= i_frag_offset;
            r_req.flen      <= i_total_length - 16'(iprt_pkg::HDR_LEN)
                               - {10'd0, i_options_length};
            r_req.olen      <= i_options_length;
            r_req.mf        <= i_more_frags;
        end
    end

    // sequencer, victim pointer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_victim <= '0;
            o_valid  <= 1'b0;
        end else begin
            // a result taken in the update cycle is replaced by the new one below
            if (o_valid && !i_stall && !upd_en) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (upd_en) begin
                        r_state <= S_IDLE;
                        o_valid <= 1'b1;
                        if (!ctl.any_hit && !ctl.any_free) begin
                            r_victim <= (r_victim == LAST) ? '0 : r_victim + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_en) begin
            o_entry_index    <= res_chain[ENTRIES].entry;
            o_new_entry      <= ~ctl.any_hit;
            o_evicted        <= ~ctl.any_hit & ~ctl.any_free;
            o_complete       <= res_chain[ENTRIES].complete;
            o_payload_length <= res_chain[ENTRIES].payload;
            o_full_length    <= res_chain[ENTRIES].full;
        end
    end

endmodule
`default_nettype wire

>>> hdl/iprt_checker.sv
// Port-level checks for the reassembly tracker, bound to the top level.
`default_nettype none
module iprt_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [2:0]  o_entry_index,
    input wire        o_new_entry,
    input wire        o_evicted,
    input wire        o_complete,
    input wire [16:0] o_payload_length,
    input wire [16:0] o_full_length
);

    // an eviction always claims the entry
    a_evict_claims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> o_new_entry)
        else $error("evicted without new entry");

    // lengths are zero unless the datagram completed
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_complete |-> (o_payload_length == 17'd0) && (o_full_length == 17'd0))
        else $error("length reported without completion");

    // full length never below the payload length, payload nonzero on completion
    a_full_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_complete |-> (o_full_length >= o_payload_length)
                                  && (o_payload_length != 17'd0))
        else $error("bad completion lengths");

    // an accepted request blocks the input in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken while busy");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_entry_index) && $stable(o_complete)
                               && $stable(o_full_length))
        else $error("stalled result changed");

endmodule

bind ip_fragment_reassembly_tracker_unit iprt_checker u_iprt_checker (.*);
`default_nettype wire
